### src/mic_pkg.sv
// Shared types, operation codes and register map of the interrupt controller.
`timescale 1ns / 1ps
`default_nettype none

package mic_pkg;

    // Operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RAISE = 2'd2;
    localparam logic [1:0] OP_ACK   = 2'd3;

    // Register offsets
    localparam logic [11:0] OFF_PENDING    = 12'h204;
    localparam logic [11:0] OFF_FORCE0     = 12'h208;
    localparam logic [11:0] OFF_CLEAR      = 12'h20C;
    localparam logic [11:0] OFF_STATUS     = 12'h210;
    localparam logic [11:0] OFF_BROADCAST  = 12'h214;
    localparam logic [11:0] OFF_MASK_BASE  = 12'h240;
    localparam logic [11:0] OFF_FORCE_BASE = 12'h280;

    // Bits kept on writes and in the level request
    localparam logic [15:0] MASK_KEEP  = 16'h7ffe;
    localparam logic [15:0] FORCE_KEEP = 16'hfffe;
    localparam logic [15:0] LEVEL_KEEP = 16'hfffe;

    localparam int unsigned CPU_SLOTS = 4;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] reg_offset;
        logic [31:0] write_data;
        logic [3:0]  irq_level;
        logic [1:0]  cpu_index;
    } req_word_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [3:0]  irl_cpu0;
        logic [3:0]  irl_cpu1;
        logic [3:0]  irl_cpu2;
        logic [3:0]  irl_cpu3;
    } rsp_word_t;

endpackage

`default_nettype wire

### src/multiprocessor_interrupt_controller_unit.sv
// Top level of the multiprocessor interrupt controller.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake               Payload
// req       req_valid / req_ready   req_word  (mic_pkg::req_word_t)
// rsp       rsp_valid / rsp_ready   rsp_word  (mic_pkg::rsp_word_t)
// cfg       cfg_we                  cfg_data  (active processor count)
//
// One word per cycle sustained while rsp does not stall; a word taken at req
// passes the input register, then the result register, before it shows up at rsp.
// The state update and the four priority encoders sit between the two
// registers, so the rate is set by that single pass, one word per clock.
// rst_n clears all controller state and sets the active count to one.
// A stall at rsp holds the result register; req keeps taking words until
// the input register is also full.

module multiprocessor_interrupt_controller_unit #(
    parameter int MAX_CPUS = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire mic_pkg::req_word_t req_word,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output mic_pkg::rsp_word_t      rsp_word,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_data
);

    logic               in_valid_reg;
    mic_pkg::req_word_t in_word_reg;
    logic               out_valid_reg;
    mic_pkg::rsp_word_t out_word_reg;
    mic_pkg::rsp_word_t out_word_next;
    logic [2:0]         active_cpus_reg;
    logic [2:0]         served;
    logic               advance;
    logic [31:0]        read_data;
    logic [15:0]        lvl_req [mic_pkg::CPU_SLOTS];
    logic [3:0]         level   [mic_pkg::CPU_SLOTS];

    // Clamp the active count into 1..MAX_CPUS
    always_comb
    begin
        priority if (active_cpus_reg == 3'd0)
        begin
            served = 3'd1;
        end
        else if (active_cpus_reg > 3'(MAX_CPUS))
        begin
            served = 3'(MAX_CPUS);
        end
        else
        begin
            served = active_cpus_reg;
        end
    end

    // Advance the held word when the result register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !in_valid_reg || advance;

    mic_state #(
        .MAX_CPUS (MAX_CPUS)
    ) u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (in_word_reg),
        .served    (served),
        .read_data (read_data),
        .lvl_req   (lvl_req)
    );

    for (genvar g = 0; g < mic_pkg::CPU_SLOTS; g++)
    begin : g_enc
        mic_prio_enc u_enc (
            .lvl_req (lvl_req[g]),
            .level   (level[g])
        );
    end

    // Read data only for a read; zero for everything else
    always_comb
    begin
        out_word_next.read_data = (in_word_reg.op == mic_pkg::OP_READ) ? read_data : 32'd0;
        out_word_next.irl_cpu0  = level[0];
        out_word_next.irl_cpu1  = level[1];
        out_word_next.irl_cpu2  = level[2];
        out_word_next.irl_cpu3  = level[3];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            active_cpus_reg <= 3'd1;
        end
        else
        begin
            if (req_ready)
            begin
                in_valid_reg <= req_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                active_cpus_reg <= cfg_data;
            end
        end
    end

    // Payload registers: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            in_word_reg <= req_word;
        end
        if (advance)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

endmodule

`default_nettype wire

### src/mic_prio_enc.sv
// Priority encoder: highest set level of a 16-bit request vector.
`timescale 1ns / 1ps
`default_nettype none

module mic_prio_enc (
    input  wire logic [15:0] lvl_req,
    output logic      [3:0]  level
);

    always_comb
    begin
        level = 4'd0;
        for (int i = 1; i < 16; i++)
        begin
            if (lvl_req[i])
            begin
                level = 4'(i);
            end
        end
    end

endmodule

`default_nettype wire

### src/mic_state.sv
// Controller state registers: update on each word and per-processor level requests.
`timescale 1ns / 1ps
`default_nettype none

module mic_state #(
    parameter int MAX_CPUS = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire mic_pkg::req_word_t   item,
    input  wire logic [2:0]           served,
    output logic      [31:0]          read_data,
    output logic      [15:0]          lvl_req [mic_pkg::CPU_SLOTS]
);

    logic [15:0] pending_reg;
    logic [15:0] pending_next;
    logic [15:0] broadcast_reg;
    logic [15:0] broadcast_next;
    logic [15:0] mask_reg   [MAX_CPUS];
    logic [15:0] mask_next  [MAX_CPUS];
    logic [15:0] force_reg  [MAX_CPUS];
    logic [15:0] force_next [MAX_CPUS];
    logic [15:0] bit_sel;
    logic        ack_hit;

    assign bit_sel = 16'd1 << item.irq_level;

    // Register read, from the state before the update
    always_comb
    begin
        read_data = '0;
        if (item.reg_offset == mic_pkg::OFF_PENDING)
        begin
            read_data = {16'd0, pending_reg};
        end
        else if (item.reg_offset == mic_pkg::OFF_FORCE0)
        begin
            read_data = {16'd0, force_reg[0]};
        end
        else if (item.reg_offset == mic_pkg::OFF_STATUS)
        begin
            read_data = (32'(served) - 32'd1) << 28;
        end
        else if (item.reg_offset == mic_pkg::OFF_BROADCAST)
        begin
            read_data = {16'd0, broadcast_reg};
        end
        else
        begin
            for (int k = 0; k < MAX_CPUS; k++)
            begin
                if (item.reg_offset == mic_pkg::OFF_MASK_BASE + 12'(4 * k))
                begin
                    read_data = {16'd0, mask_reg[k]};
                end
                if (item.reg_offset == mic_pkg::OFF_FORCE_BASE + 12'(4 * k))
                begin
                    read_data = {16'd0, force_reg[k]};
                end
            end
        end
    end

    always_comb
    begin
        ack_hit = 1'b0;
        for (int k = 0; k < MAX_CPUS; k++)
        begin
            if (item.cpu_index == 2'(k) && (force_reg[k] & bit_sel) != 16'd0)
            begin
                ack_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        pending_next   = pending_reg;
        broadcast_next = broadcast_reg;
        for (int k = 0; k < MAX_CPUS; k++)
        begin
            mask_next[k]  = mask_reg[k];
            force_next[k] = force_reg[k];
        end
        if (advance)
        begin
            unique case (item.op)
                mic_pkg::OP_READ:
                begin
                end
                mic_pkg::OP_WRITE:
                begin
                    if (item.reg_offset == mic_pkg::OFF_FORCE0)
                    begin
                        force_next[0] = item.write_data[15:0] & mic_pkg::FORCE_KEEP;
                    end
                    else if (item.reg_offset == mic_pkg::OFF_CLEAR)
                    begin
                        pending_next = pending_reg & ~item.write_data[15:0]
                                       & mic_pkg::LEVEL_KEEP;
                    end
                    else if (item.reg_offset == mic_pkg::OFF_BROADCAST)
                    begin
                        broadcast_next = item.write_data[15:0] & mic_pkg::FORCE_KEEP;
                    end
                    else
                    begin
                        for (int k = 0; k < MAX_CPUS; k++)
                        begin
                            if (item.reg_offset == mic_pkg::OFF_MASK_BASE + 12'(4 * k))
                            begin
                                mask_next[k] = item.write_data[15:0] & mic_pkg::MASK_KEEP;
                            end
                            if (item.reg_offset == mic_pkg::OFF_FORCE_BASE + 12'(4 * k))
                            begin
                                force_next[k] = item.write_data[15:0] & mic_pkg::FORCE_KEEP;
                            end
                        end
                    end
                end
                mic_pkg::OP_RAISE:
                begin
                    if ((broadcast_reg & bit_sel) != 16'd0)
                    begin
                        for (int k = 0; k < MAX_CPUS; k++)
                        begin
                            if (3'(k) < served)
                            begin
                                force_next[k] = force_reg[k] | bit_sel;
                            end
                        end
                    end
                    else
                    begin
                        pending_next = pending_reg | bit_sel;
                    end
                end
                mic_pkg::OP_ACK:
                begin
                    if (ack_hit)
                    begin
                        for (int k = 0; k < MAX_CPUS; k++)
                        begin
                            if (item.cpu_index == 2'(k))
                            begin
                                force_next[k] = force_reg[k] & ~bit_sel;
                            end
                        end
                    end
                    else
                    begin
                        pending_next = pending_reg & ~bit_sel;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            broadcast_reg <= '0;
            for (int k = 0; k < MAX_CPUS; k++)
            begin
                mask_reg[k]  <= '0;
                force_reg[k] <= '0;
            end
        end
        else
        begin
            pending_reg   <= pending_next;
            broadcast_reg <= broadcast_next;
            for (int k = 0; k < MAX_CPUS; k++)
            begin
                mask_reg[k]  <= mask_next[k];
                force_reg[k] <= force_next[k];
            end
        end
    end

    // Level requests after the update; inactive or absent processors see none
    for (genvar g = 0; g < mic_pkg::CPU_SLOTS; g++)
    begin : g_req
        if (g < MAX_CPUS)
        begin : g_present
            assign lvl_req[g] = (3'(g) < served)
                ? ((pending_next | force_next[g]) & mask_next[g] & mic_pkg::LEVEL_KEEP)
                : 16'd0;
        end
        else
        begin : g_absent
            assign lvl_req[g] = 16'd0;
        end
    end

endmodule

`default_nettype wire

### src/mic_checker.sv
// Port-level checker for the interrupt controller and its bind.
`timescale 1ns / 1ps
`default_nettype none

module mic_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_valid,
    input wire logic               req_ready,
    input wire logic               rsp_valid,
    input wire logic               rsp_ready,
    input wire mic_pkg::rsp_word_t rsp_word
);

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
        else $error("stalled result word changed or dropped");

    // With an empty output side the input side is never blocked
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("req blocked while no result is held");

    // A new result follows an accepted word through the input and result registers
    a_rsp_from_req: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("result appeared without a matching accepted word");

    // Level 15 is always cleared by the MASK_KEEP mask on the mask registers
    a_no_level15: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_word.irl_cpu0 != 4'd15) && (rsp_word.irl_cpu1 != 4'd15)
                      && (rsp_word.irl_cpu2 != 4'd15) && (rsp_word.irl_cpu3 != 4'd15))
        else $error("level 15 reached an output");

endmodule

bind multiprocessor_interrupt_controller_unit mic_checker u_mic_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_word  (rsp_word)
);

`default_nettype wire
